/* hdl/pkrl_pkg.sv */
// Shared types and constants of the per-key event rate limiter.
`default_nettype none
package pkrl_pkg;

  localparam int HANDLER_KINDS = 16;
  localparam int ERROR_KINDS   = 16;
  localparam int TABLE_DEPTH   = HANDLER_KINDS * ERROR_KINDS;
  localparam int KEY_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int TIME_W  = 64;
  localparam int ID_W    = 4;
  localparam int WIN_W   = 32;
  localparam int MAXP_W  = 8;
  localparam int HELD_W  = 32;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_WINDOW_MS  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_PASSED = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BACKSTEP   = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 32'd21600000;
  localparam logic [MAXP_W-1:0] MAX_PASSED_RESET = 8'd3;
  localparam logic [WIN_W-1:0]  BACKSTEP_RESET = 32'd120000;

  typedef struct packed {
    logic [TIME_W-1:0] window_start;
    logic [MAXP_W-1:0] passed_count;
    logic [HELD_W-1:0] held_count;
  } pkrl_entry_t;

  typedef struct packed {
    logic              clear_all;
    logic [TIME_W-1:0] now;
  } pkrl_time_t;

  typedef struct packed {
    logic              pass_event;
    logic [HELD_W-1:0] suppressed_count;
  } pkrl_result_t;

endpackage
`default_nettype wire

/* hdl/pkrl_time.sv */
// Time tracker: last seen time, backward step detection and hold.
`default_nettype none
module pkrl_time (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [pkrl_pkg::TIME_W-1:0] now_ms,
  input  wire logic [pkrl_pkg::WIN_W-1:0]  backstep_tolerance_ms,
  output pkrl_pkg::pkrl_time_t            tinfo
);
  import pkrl_pkg::*;

  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] back_diff;
  logic              backward;
  logic              too_far;

  always_comb begin
    backward  = now_ms < last_time;
    back_diff = last_time - now_ms;
    too_far   = backward && (back_diff > {{(TIME_W-WIN_W){1'b0}}, backstep_tolerance_ms});
    tinfo.clear_all = too_far;
    tinfo.now       = (backward && !too_far) ? last_time : now_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (accept) begin
      last_time <= tinfo.now;
    end
  end

  // time never steps back past the tolerance without a table clear
  a_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !tinfo.clear_all |-> tinfo.now >= last_time)
    else $error("pkrl_time: held time went backward");

endmodule
`default_nettype wire

/* hdl/pkrl_table.sv */
// Per-key state table: entry memory with registered read, valid bits in flops.
`default_nettype none
module pkrl_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [pkrl_pkg::KEY_W-1:0] rd_addr,
  output pkrl_pkg::pkrl_entry_t           rd_data,
  input  wire logic [pkrl_pkg::KEY_W-1:0] cur_key,
  output logic                            cur_valid,
  input  wire logic                       clear_all,
  input  wire logic                       wr_en,
  input  wire pkrl_pkg::pkrl_entry_t      wr_data
);
  import pkrl_pkg::*;

  pkrl_entry_t            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_key] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[cur_key] <= 1'b1;
    end
  end

  assign cur_valid = valid[cur_key];

  a_set: assert property (@(posedge clk) disable iff (rst)
    wr_en && !clear_all |=> valid[$past(cur_key)])
    else $error("pkrl_table: written entry not marked valid");

  a_clr: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> valid == '0)
    else $error("pkrl_table: table clear left a valid entry");

endmodule
`default_nettype wire

/* hdl/pkrl_entry_calc.sv */
// Entry update: window expiry, pass limit and saturating suppressed count.
`default_nettype none
module pkrl_entry_calc (
  input  wire logic                        in_range,
  input  wire logic                        entry_valid,
  input  wire pkrl_pkg::pkrl_entry_t       entry_in,
  input  wire logic [pkrl_pkg::TIME_W-1:0] now,
  input  wire logic [pkrl_pkg::WIN_W-1:0]  window_ms,
  input  wire logic [pkrl_pkg::MAXP_W-1:0] max_passed,
  output pkrl_pkg::pkrl_entry_t            entry_out,
  output logic                             wr,
  output pkrl_pkg::pkrl_result_t           result
);
  import pkrl_pkg::*;

  logic [TIME_W:0] age_raw;
  logic            expired;

  always_comb begin
    // borrow out means now is before the window start: age counts as zero
    age_raw = {1'b0, now} - {1'b0, entry_in.window_start};
    expired = !age_raw[TIME_W]
              && (age_raw[TIME_W-1:0] > {{(TIME_W-WIN_W){1'b0}}, window_ms});

    entry_out = entry_in;
    wr        = in_range;
    result.pass_event       = 1'b1;
    result.suppressed_count = '0;

    if (in_range) begin
      if (!entry_valid || expired) begin
        entry_out.window_start = now;
        entry_out.passed_count = MAXP_W'(1);
        entry_out.held_count   = '0;
        if (entry_valid) begin
          result.suppressed_count = entry_in.held_count;
        end
      end else if (entry_in.passed_count < max_passed) begin
        entry_out.passed_count  = entry_in.passed_count + MAXP_W'(1);
        entry_out.held_count    = '0;
        result.suppressed_count = entry_in.held_count;
      end else begin
        result.pass_event = 1'b0;
        if (entry_in.held_count != '1) begin
          entry_out.held_count = entry_in.held_count + HELD_W'(1);
        end
        result.suppressed_count = entry_out.held_count;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/per_key_event_rate_limiter_core.sv */
// Per-key event rate limiter: top level with handshake, config and sequencing.
//
// Input stream s_*: one word per event (now_ms, handler_id, error_class).
// Output stream m_*: one word per event (pass_event, suppressed_count).
// Config port: cfg_we/cfg_index/cfg_data, to be written by the user only while
// idle; the block does not enforce this. Index 0 window_ms, 1 max_passed,
// 2 backstep tolerance, others ignored.
// In the idle state the accept cycle issues the table read and settles the
// time (backstep hold or table clear); in the update state that follows, the
// entry read-modify-write is done and the output register loaded, once that
// register is free. A new event is not accepted until the previous one has
// left the update state. s_tready is high only in the idle state; a result
// still waiting in the output register does not block acceptance. If the
// receiver stalls with a result pending, the next event waits in the update
// state and s_tready stays low until the output register frees.
// Reset clears all valid bits at once (no clearing pass), sets last time
// to zero and the registers to their defaults.
`default_nettype none
module per_key_event_rate_limiter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [63:0] now_ms, [67:64] handler_id, [71:68] error_class
  input  wire logic [pkrl_pkg::S_DATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] pass_event, [32:1] suppressed_count, [39:33] zero
  output logic [pkrl_pkg::M_DATA_W-1:0]      m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [pkrl_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [pkrl_pkg::CFG_W-1:0]    cfg_data
);
  import pkrl_pkg::*;

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t             state;
  logic [WIN_W-1:0]   window_ms;
  logic [MAXP_W-1:0]  max_passed;
  logic [WIN_W-1:0]   backstep_tolerance_ms;

  logic [TIME_W-1:0]  now_q;
  logic [KEY_W-1:0]   key_q;
  logic               in_range_q;

  logic               accept;
  logic               out_free;
  logic [ID_W-1:0]    handler_id;
  logic [ID_W-1:0]    error_class;
  logic               in_range;
  logic [KEY_W-1:0]   key;

  pkrl_time_t         tinfo;
  pkrl_entry_t        rd_entry;
  pkrl_entry_t        wr_entry;
  logic               cur_valid;
  logic               calc_wr;
  logic               tbl_wr;
  pkrl_result_t       result;

  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign handler_id  = s_tdata[TIME_W +: ID_W];
  assign error_class = s_tdata[TIME_W+ID_W +: ID_W];
  assign in_range    = (32'(handler_id) < 32'(HANDLER_KINDS))
                       && (32'(error_class) < 32'(ERROR_KINDS));
  assign key         = KEY_W'(32'(handler_id) * 32'(ERROR_KINDS) + 32'(error_class));
  assign tbl_wr      = (state == S_UPD) && out_free && calc_wr;

  pkrl_time u_time (
    .clk                   (clk),
    .rst                   (rst),
    .accept                (accept),
    .now_ms                (s_tdata[TIME_W-1:0]),
    .backstep_tolerance_ms (backstep_tolerance_ms),
    .tinfo                 (tinfo)
  );

  pkrl_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (key),
    .rd_data   (rd_entry),
    .cur_key   (key_q),
    .cur_valid (cur_valid),
    .clear_all (accept && tinfo.clear_all),
    .wr_en     (tbl_wr),
    .wr_data   (wr_entry)
  );

  pkrl_entry_calc u_calc (
    .in_range    (in_range_q),
    .entry_valid (cur_valid),
    .entry_in    (rd_entry),
    .now         (now_q),
    .window_ms   (window_ms),
    .max_passed  (max_passed),
    .entry_out   (wr_entry),
    .wr          (calc_wr),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms             <= WINDOW_RESET;
      max_passed            <= MAX_PASSED_RESET;
      backstep_tolerance_ms <= BACKSTEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_MS:  window_ms             <= cfg_data[WIN_W-1:0];
        REG_MAX_PASSED: max_passed            <= cfg_data[MAXP_W-1:0];
        REG_BACKSTEP:   backstep_tolerance_ms <= cfg_data[WIN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept) begin
            now_q      <= tinfo.now;
            key_q      <= key;
            in_range_q <= in_range;
            state      <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(M_DATA_W-HELD_W-1){1'b0}},
                         result.suppressed_count, result.pass_event};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_upd_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_UPD && m_tvalid == $past(m_tvalid && !m_tready))
    else $error("pkrl: accepted word did not move to update");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && m_tvalid && !m_tready |=> state == S_UPD && !$past(tbl_wr))
    else $error("pkrl: update completed into a full output register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && out_free |=> m_tvalid && state == S_IDLE)
    else $error("pkrl: finished update produced no result");

endmodule
`default_nettype wire

/* bench/pkrl_checker.sv */
// Scoreboard for the rate limiter: mirrors its key table, predicts each verdict and checks it.
module pkrl_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [pkrl_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [pkrl_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [pkrl_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pkrl_pkg::CFG_W-1:0]    cfg_data,
  output int unsigned                   pending,
  output int                            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pkrl_pkg::*;

  logic [WIN_W-1:0]  win_len;
  logic [MAXP_W-1:0] pass_limit;
  logic [WIN_W-1:0]  back_tol;

  logic              live_tab   [TABLE_DEPTH];
  logic [TIME_W-1:0] start_tab  [TABLE_DEPTH];
  logic [MAXP_W-1:0] passes_tab [TABLE_DEPTH];
  logic [HELD_W-1:0] held_tab   [TABLE_DEPTH];
  logic [TIME_W-1:0] last_ms;

  pkrl_result_t verdict_q[$];
  pkrl_result_t want;
  int unsigned  words_in;
  int unsigned  words_out;

  assign pending = words_in - words_out;

  function automatic pkrl_result_t rate_decide(input logic [TIME_W-1:0] now_in,
                                               input logic [ID_W-1:0]   hid,
                                               input logic [ID_W-1:0]   ecl);
    pkrl_result_t      r;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] age;
    logic [KEY_W-1:0]  k;
    r.pass_event       = 1'b1;
    r.suppressed_count = '0;
    t = now_in;
    if (t < last_ms) begin
      // a big step back wipes the table, a small one is absorbed
      if (last_ms - t > TIME_W'(back_tol)) begin
        foreach (live_tab[i]) live_tab[i] = 1'b0;
      end else begin
        t = last_ms;
      end
    end
    // ids outside the table pass untouched
    if ((32'(hid) < 32'(HANDLER_KINDS)) && (32'(ecl) < 32'(ERROR_KINDS))) begin
      k = KEY_W'(32'(hid) * 32'(ERROR_KINDS) + 32'(ecl));
      if (!live_tab[k]) begin
        live_tab[k]   = 1'b1;
        start_tab[k]  = t;
        passes_tab[k] = 8'd1;
        held_tab[k]   = '0;
      end else begin
        age = (t > start_tab[k]) ? t - start_tab[k] : '0;
        if (age > TIME_W'(win_len)) begin
          r.suppressed_count = held_tab[k];
          start_tab[k]  = t;
          passes_tab[k] = 8'd1;
          held_tab[k]   = '0;
        end else if (passes_tab[k] < pass_limit) begin
          passes_tab[k]      = passes_tab[k] + 8'd1;
          r.suppressed_count = held_tab[k];
          held_tab[k]        = '0;
        end else begin
          r.pass_event = 1'b0;
          if (held_tab[k] != '1) held_tab[k] = held_tab[k] + 1'b1;
          r.suppressed_count = held_tab[k];
        end
      end
    end
    last_ms = t;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_len    = WINDOW_RESET;
      pass_limit = MAX_PASSED_RESET;
      back_tol   = BACKSTEP_RESET;
      foreach (live_tab[i]) live_tab[i] = 1'b0;
      last_ms    = '0;
      verdict_q.delete();
      fail_count = 0;
      words_in  <= 0;
      words_out <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_MS:  win_len    = cfg_data[WIN_W-1:0];
          REG_MAX_PASSED: pass_limit = cfg_data[MAXP_W-1:0];
          REG_BACKSTEP:   back_tol   = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      // check the outgoing word first: a word accepted this edge cannot answer yet
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected, actual pass_event %0b suppressed_count %0d",
                   $time, m_tdata[0], m_tdata[32:1]);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.pass_event) begin
            $display("%0t: pass_event expected %0b actual %0b",
                     $time, want.pass_event, m_tdata[0]);
            fail_count++;
          end
          if (m_tdata[32:1] !== want.suppressed_count) begin
            $display("%0t: suppressed_count expected %0d actual %0d",
                     $time, want.suppressed_count, m_tdata[32:1]);
            fail_count++;
          end
          words_out <= words_out + 1;
        end
      end
      if (s_tvalid && s_tready) begin
        verdict_q.push_back(rate_decide(s_tdata[63:0], s_tdata[67:64], s_tdata[71:68]));
        words_in <= words_in + 1;
      end
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the rate limiter: clock, reset, register phases, event stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pkrl_pkg::*;

  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;   // unused index, must be ignored

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  // [63:0] now_ms, [67:64] handler_id, [71:68] error_class
  logic [S_DATA_W-1:0] s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  // [0] pass_event, [32:1] suppressed_count, [39:33] zero
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_we    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  int unsigned pending;
  int          fail_count;

  logic              steady     = 1'b0;
  logic [TIME_W-1:0] now_cursor = '0;
  logic [WIN_W-1:0]  win_now    = WINDOW_RESET;
  logic [WIN_W-1:0]  tol_now    = BACKSTEP_RESET;
  int unsigned       step_span  = 1000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  per_key_event_rate_limiter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pkrl_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 9);
  end

  task automatic send_event(input logic [TIME_W-1:0] now,
                            input logic [ID_W-1:0]   hid,
                            input logic [ID_W-1:0]   ecl);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 9) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ecl, hid, now};
    do @(posedge clk); while (!s_tready);
    now_cursor = now;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [WIN_W-1:0]  win,
                              input logic [MAXP_W-1:0] lim,
                              input logic [WIN_W-1:0]  tol);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_MS;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= REG_MAX_PASSED;
    cfg_data  <= {24'($urandom), lim};   // upper bits must be dropped
    @(posedge clk);
    cfg_index <= REG_BACKSTEP;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_now = win;
    tol_now = tol;
  endtask

  // mostly small forward steps; back steps, window jumps and wild values now and then
  function automatic logic [TIME_W-1:0] next_now();
    int unsigned       pick;
    logic [TIME_W-1:0] tol64;
    logic [TIME_W-1:0] win64;
    pick  = steady ? $urandom_range(0, 59) : $urandom_range(0, 99);
    tol64 = TIME_W'(tol_now);
    win64 = TIME_W'(win_now);
    if (pick < 45) return now_cursor + TIME_W'($urandom_range(0, step_span));
    if (pick < 60) return now_cursor;
    if (pick < 70) return now_cursor - TIME_W'($urandom_range(0, tol_now));
    if (pick < 75) return now_cursor - tol64 - 64'd1 - TIME_W'($urandom_range(0, 1000));
    if (pick < 86) return now_cursor + win64 + 64'd1 + TIME_W'($urandom_range(0, step_span));
    if (pick < 90) return now_cursor + win64;
    if (pick < 97) return {$urandom(), $urandom()};
    return '1 - TIME_W'($urandom_range(0, step_span));
  endfunction

  // most events hit a small pool of keys so that limits are reached
  task automatic random_events(input int count, input int span);
    logic [ID_W-1:0] base_h;
    logic [ID_W-1:0] base_e;
    base_h = ID_W'($urandom());
    base_e = ID_W'($urandom());
    repeat (count) begin
      if ($urandom_range(0, 99) < 80)
        send_event(next_now(), ID_W'(base_h + $urandom_range(0, span - 1)),
                   ID_W'(base_e + $urandom_range(0, span - 1)));
      else
        send_event(next_now(), ID_W'($urandom()), ID_W'($urandom()));
    end
  endtask

  initial begin
    logic [WIN_W-1:0] rand_win;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // defaults: fill a key to its limit, window boundary, back steps either side of tolerance
    send_event(64'd0, 4'd0, 4'd0);
    send_event(64'd0, 4'd0, 4'd0);
    send_event(64'd0, 4'd0, 4'd0);
    send_event(64'd0, 4'd0, 4'd0);
    send_event(64'd21600000, 4'd0, 4'd0);
    send_event(64'd21600001, 4'd0, 4'd0);
    send_event(64'd21600001, 4'd15, 4'd15);
    send_event(64'd21480001, 4'd0, 4'd0);
    send_event(64'd21480000, 4'd0, 4'd0);
    send_event('1, 4'd5, 4'd10);
    send_event(64'd0, 4'd10, 4'd5);
    random_events(150, 2);
    drain_results();

    // shortest window, one pass per window, no tolerance
    program_regs(32'd1, 8'd1, 32'd0);
    step_span = 2;
    send_event(64'd1000, 4'd3, 4'd12);
    send_event(64'd1001, 4'd3, 4'd12);
    send_event(64'd1002, 4'd3, 4'd12);
    send_event(64'd1001, 4'd3, 4'd12);
    random_events(120, 3);
    drain_results();

    // longest window and tolerance, highest limit, no idling on either side
    program_regs('1, 8'd255, '1);
    step_span = 1000;
    steady    = 1'b1;
    random_events(360, 1);
    steady    = 1'b0;
    drain_results();

    // zero limit: only a fresh window passes
    program_regs(32'd5000, 8'd0, 32'd100);
    step_span = 600;
    send_event(64'h0000_0100_0000_0000, 4'd7, 4'd7);
    send_event(64'h0000_0100_0000_0000, 4'd7, 4'd7);
    send_event(64'h0000_0100_0000_0000, 4'd7, 4'd7);
    random_events(120, 2);
    drain_results();

    rand_win = $urandom_range(1000, 200000);
    program_regs(rand_win, 8'($urandom_range(1, 8)), $urandom());
    step_span = rand_win / 8;
    random_events(150, 4);
    drain_results();

    if (fail_count == 0)
      $display("per_key_event_rate_limiter_core: match");
    else
      $display("per_key_event_rate_limiter_core: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("per_key_event_rate_limiter_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
hdl/pkrl_pkg.sv
hdl/pkrl_time.sv
hdl/pkrl_table.sv
hdl/pkrl_entry_calc.sv
hdl/per_key_event_rate_limiter_core.sv
bench/pkrl_checker.sv
bench/tb_top.sv
